### rtl/seven_segment_scan_driver_assert.svh
// Assertion macros for the seven-segment scan driver.
// Needs no package; used by files that carry concurrent checks.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define SSSD_ASSERT_SAME(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is held.
`define SSSD_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/sssd_pkg.sv
// Types, constants and segment table for the seven-segment scan driver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

    typedef logic [3:0] digit_t;
    typedef digit_t [3:0] digits_t;   // index 0 is the leftmost (thousands) digit
    typedef logic [7:0] seg_t;        // bit 0 goes out first (DP)

    localparam logic [15:0] OVERFLOW_LIMIT = 16'd9999;
    localparam int unsigned BIN_W = 14;  // 9999 fits in 14 bits

    localparam logic [1:0] POS_LEFT  = 2'd0;
    localparam logic [1:0] POS_RIGHT = 2'd3;

    localparam seg_t SEG_E = 8'b0110_0001;

    // Active-low common-anode patterns, bit i is shifted out i-th.
    function automatic seg_t seg_lookup(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 8'b0000_0011;
            4'd1:    s = 8'b1001_1111;
            4'd2:    s = 8'b0010_0101;
            4'd3:    s = 8'b0000_1101;
            4'd4:    s = 8'b1001_1001;
            4'd5:    s = 8'b0100_1001;
            4'd6:    s = 8'b0100_0001;
            4'd7:    s = 8'b0001_1111;
            4'd8:    s = 8'b0000_0001;
            4'd9:    s = 8'b0000_1001;
            default: s = SEG_E;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/sssd_bcd.sv
// Splits a binary value below 10000 into four decimal digits.
// Uses reciprocal multiplies by constants; depends on sssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sssd_bcd
    import sssd_pkg::*;
(
    input  wire logic [BIN_W-1:0] bin,
    output digits_t               digits
);

    logic [27:0] p1000;
    logic [27:0] p100;
    logic [27:0] p10;
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [6:0]  r1;
    logic [9:0]  r2;
    logic [13:0] r3;

    // x/1000 ~ x*8389>>23, x/100 ~ x*5243>>19, x/10 ~ x*6554>>16, exact for x < 10000
    assign p1000 = 28'(bin) * 28'd8389;
    assign p100  = 28'(bin) * 28'd5243;
    assign p10   = 28'(bin) * 28'd6554;

    assign q1000 = p1000[26:23];
    assign q100  = p100[25:19];
    assign q10   = p10[25:16];

    // remainder = quotient - 10 * coarser quotient
    assign r1 = q100 - ({q1000, 3'b000} + 7'({q1000, 1'b0}));
    assign r2 = q10 - ({q100, 3'b000} + 10'({q100, 1'b0}));
    assign r3 = bin - (14'({q10, 3'b000}) + 14'({q10, 1'b0}));

    assign digits[0] = q1000;
    assign digits[1] = r1[3:0];
    assign digits[2] = r2[3:0];
    assign digits[3] = r3[3:0];

endmodule

`default_nettype wire

### rtl/seven_segment_scan_driver.sv
// Four-digit multiplexed seven-segment scan driver, serial segment output.
// A transfer at the input is held in the input register, then loads the output
// shifter, which presents its first bit. Each item shifts out as an 8-bit byte;
// the next item enters the input register while the current byte shifts out.
// Reset (aresetn low, synchronous): scan at leftmost digit, leading-zero flag
// clear, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_scan_driver_assert.svh"

module seven_segment_scan_driver
    import sssd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_serial_bit,
    output logic [3:0]       m_digit_enables_n,
    output logic             m_latch
);

    // input stage
    logic    in_valid_reg;
    logic    in_ovf_reg;
    digits_t in_digits_reg;
    digits_t bcd_digits;

    // scan state
    logic [1:0] pos_reg,  pos_next;
    logic       lzr_reg,  lzr_next;

    // output shifter
    logic       m_valid_reg;
    seg_t       sh_reg;
    logic [2:0] cnt_reg;
    logic [3:0] en_reg;

    logic       last;
    logic       load;
    digit_t     cur_digit;
    logic       blank;
    seg_t       load_seg;
    logic [3:0] load_en;

    sssd_bcd u_bcd (
        .bin    (s_value[BIN_W-1:0]),
        .digits (bcd_digits)
    );

    assign last    = (cnt_reg == 3'd7);
    assign load    = in_valid_reg && (!m_valid_reg || (m_ready && last));
    assign s_ready = !in_valid_reg || load;

    assign cur_digit = in_digits_reg[pos_reg];

    always_comb begin
        blank    = 1'b0;
        lzr_next = lzr_reg;
        pos_next = pos_reg;
        load_seg = SEG_E;
        load_en  = 4'h0;
        if (!in_ovf_reg) begin
            unique case (pos_reg)
                POS_LEFT: begin
                    blank    = (cur_digit == 4'd0);
                    lzr_next = blank;
                end
                POS_RIGHT: begin
                    blank    = 1'b0;
                    lzr_next = 1'b0;
                end
                default: begin
                    blank = (cur_digit == 4'd0) && lzr_reg;
                    if (!blank) begin
                        lzr_next = 1'b0;
                    end
                end
            endcase
            pos_next = pos_reg + 2'd1;
            load_seg = seg_lookup(cur_digit);
            load_en  = blank ? 4'hF : ~(4'b0001 << pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ovf_reg    <= (s_value > OVERFLOW_LIMIT);
            in_digits_reg <= bcd_digits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_LEFT;
            lzr_reg <= 1'b0;
        end else if (load) begin
            pos_reg <= pos_next;
            lzr_reg <= lzr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= 3'd0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            cnt_reg     <= 3'd0;
        end else if (m_valid_reg && m_ready) begin
            if (last) begin
                m_valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sh_reg <= load_seg;
            en_reg <= load_en;
        end else if (m_valid_reg && m_ready) begin
            sh_reg <= {1'b0, sh_reg[7:1]};
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_serial_bit      = sh_reg[0];
    assign m_digit_enables_n = en_reg;
    assign m_latch           = last;

    `SSSD_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid_reg && m_ready && !last, m_valid_reg, "byte run dropped before its eighth bit")
    `SSSD_ASSERT_NEXT(a_load_starts_run, aclk, aresetn, load, m_valid_reg && cnt_reg == 3'd0, "load did not start a fresh run")
    `SSSD_ASSERT_NEXT(a_scan_advances, aclk, aresetn, load && !in_ovf_reg, pos_reg == $past(pos_reg) + 2'd1, "scan position did not advance")
    `SSSD_ASSERT_NEXT(a_ovf_holds_state, aclk, aresetn, load && in_ovf_reg, $stable(pos_reg) && $stable(lzr_reg), "overflow changed scan state")
    `SSSD_ASSERT_SAME(a_right_always_lit, aclk, aresetn, load && !in_ovf_reg && pos_reg == POS_RIGHT, load_en == 4'b0111, "rightmost digit blanked")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for seven_segment_scan_driver: directed digit cases, random scans
// under sender/receiver idling, and a long output stall. Depends on sssd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import sssd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam int DIGIT_E        = 10;

    // Active-low segment bytes in shift order: element 0 (DP) goes out first.
    localparam logic [0:7] SEG_BYTE [0:10] = '{
        8'b1100_0000, 8'b1111_1001, 8'b1010_0100, 8'b1011_0000,
        8'b1001_1001, 8'b1001_0010, 8'b1000_0010, 8'b1111_1000,
        8'b1000_0000, 8'b1001_0000, 8'b1000_0110
    };

    typedef struct packed {
        logic       serial_bit;
        logic [3:0] enables_n;
        logic       latch;
    } seg_beat_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_serial_bit;
    logic [3:0]  m_digit_enables_n;
    logic        m_latch;

    seg_beat_t   pending_beats [$];
    logic [1:0]  scan_pos = POS_LEFT;
    logic        zero_run = 1'b0;
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    always #6 aclk = ~aclk;

    seven_segment_scan_driver u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_serial_bit      (m_serial_bit),
        .m_digit_enables_n (m_digit_enables_n),
        .m_latch           (m_latch)
    );

    // Works out the eight beats one refresh value produces and advances the scan unless the value overflows.
    function automatic void predict_refresh(input logic [15:0] v);
        int        digit;
        int        pattern;
        logic      blank;
        logic [3:0] en_n;
        seg_beat_t beat;
        if (v > OVERFLOW_LIMIT) begin
            pattern = DIGIT_E;
            en_n    = 4'h0;
        end else begin
            case (scan_pos)
                2'd0:    digit = (int'(v) / 1000) % 10;
                2'd1:    digit = (int'(v) / 100) % 10;
                2'd2:    digit = (int'(v) / 10) % 10;
                default: digit = int'(v) % 10;
            endcase
            pattern = digit;
            if (scan_pos == POS_LEFT) begin
                blank    = (digit == 0);
                zero_run = blank;
            end else if (scan_pos == POS_RIGHT) begin
                blank    = 1'b0;
                zero_run = 1'b0;
            end else begin
                blank = (digit == 0) && zero_run;
                if (!blank)
                    zero_run = 1'b0;
            end
            en_n     = blank ? 4'hF : ~(4'b0001 << scan_pos);
            scan_pos = scan_pos + 2'd1;
        end
        for (int i = 0; i < 8; i++) begin
            beat.serial_bit = SEG_BYTE[pattern][i];
            beat.enables_n  = en_n;
            beat.latch      = (i == 7);
            pending_beats.push_back(beat);
        end
    endfunction

    // Output side: random stalls, plus a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        seg_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected output transfer: bit %0b enables %h latch %0b",
                       m_serial_bit, m_digit_enables_n, m_latch);
                failures++;
            end else begin
                exp_beat = pending_beats.pop_front();
                if (m_serial_bit !== exp_beat.serial_bit) begin
                    $error("m_serial_bit: expected %0b, got %0b",
                           exp_beat.serial_bit, m_serial_bit);
                    failures++;
                end
                if (m_digit_enables_n !== exp_beat.enables_n) begin
                    $error("m_digit_enables_n: expected %h, got %h",
                           exp_beat.enables_n, m_digit_enables_n);
                    failures++;
                end
                if (m_latch !== exp_beat.latch) begin
                    $error("m_latch: expected %0b, got %0b", exp_beat.latch, m_latch);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_value(input logic [15:0] v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_refresh(v);
    endtask

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(10000, 65535));
            1:       return 16'($urandom);
            2, 3:    return 16'($urandom_range(0, 99));
            4:       return 16'($urandom_range(0, 999));
            5:       return 16'($urandom_range(0, 9));
            default: return 16'($urandom_range(0, 9999));
        endcase
    endfunction

    task automatic test_directed_digits();
        logic [15:0] vals [$];
        vals = '{16'd0, 16'd0, 16'd0, 16'd0,
                 16'd1234, 16'd1234, 16'd65535, 16'd1234, 16'd1234,
                 16'd76, 16'd76, 16'd76, 16'd76,
                 16'd1005, 16'd1005, 16'd10000, 16'd1005, 16'd1005,
                 16'd505, 16'd505, 16'd505, 16'd505,
                 16'd9999, 16'd7890};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    // Mostly full four-digit scans of one value, with stray single refreshes mixed in.
    task automatic test_random_scans(input int idle_pct, input int stall_pct,
                                     input int n_items);
        int          sent;
        logic [15:0] v;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (sent < n_items) begin
            v = random_value();
            if ($urandom_range(0, 3) != 0 && v <= OVERFLOW_LIMIT) begin
                repeat (4) send_value(v);
                sent += 4;
            end else begin
                send_value(v);
                sent++;
            end
        end
    endtask

    task automatic test_input_stall();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        repeat (30) send_value(random_value());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_digits();
        test_random_scans(0, 0, 70);
        test_random_scans(51, 0, 70);
        test_random_scans(0, 51, 70);
        test_random_scans(26, 26, 70);
        test_input_stall();
        test_random_scans(0, 0, 20);
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sssd_pkg.sv
rtl/sssd_bcd.sv
rtl/seven_segment_scan_driver.sv
sim/tb_top.sv
